// File: src/alkv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package alkv_pkg;

  localparam int SLOTS  = 2048;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int PTR_W  = $clog2(SLOTS + 1);

  localparam logic [31:0] ERASED = 32'hFFFF_FFFF;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] status_t;

  localparam cmd_t CMD_INIT   = 2'd0;
  localparam cmd_t CMD_WRITE  = 2'd1;
  localparam cmd_t CMD_READ   = 2'd2;
  localparam cmd_t CMD_FORMAT = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_NOT_READY = 2'd2;

endpackage

`default_nettype wire

// File: src/alkv_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module alkv_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/append_log_key_value_store.sv
// result path: init, format, write, a read of an empty log and any not-ready item go from
//   accept through S_RESP to the output register; other reads first walk 1 to SLOTS = 2048
//   slots newest to oldest, one per cycle through the single registered slot memory read port
// throughput: one item at a time; next item accepted once the result is in the output register
// reset: pointer 0, not ready, no result pending; the slot memory is not cleared, the write
//   pointer acts as a fill count and slots at or above it are never read
`timescale 1ns / 1ps
`default_nettype none

module append_log_key_value_store (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire alkv_pkg::cmd_t   in_command,
  input  wire logic [31:0]      in_key,
  input  wire logic [31:0]      in_write_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output alkv_pkg::status_t     out_status,
  output logic [31:0]           out_read_data
);

  import alkv_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic              ready_r, ready_nxt;
  logic [31:0]       key_r, key_nxt;
  logic [ADDR_W-1:0] cur_r, cur_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [31:0]       res_data_r, res_data_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [31:0]       out_data_r, out_data_nxt;

  logic              in_accept;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [63:0]       mem_wdata, mem_rdata;
  logic [31:0]       rd_key, rd_val;
  logic              hit;
  logic [ADDR_W-1:0] wr_slot;
  logic [PTR_W-1:0]  ptr_dec;

  alkv_ram #(
    .DEPTH(SLOTS),
    .WIDTH(64)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_data = out_data_r;

  assign rd_key = mem_rdata[63:32];
  assign rd_val = mem_rdata[31:0];
  assign hit    = (rd_key != ERASED) && (rd_val != ERASED) && (rd_key == key_r);

  // full log wraps to slot 0 after an implicit erase
  assign wr_slot = (ptr_r == PTR_W'(SLOTS)) ? '0 : ptr_r[ADDR_W-1:0];
  assign ptr_dec = ptr_r - PTR_W'(1);

  always_comb begin
    state_nxt      = state_r;
    ptr_nxt        = ptr_r;
    ready_nxt      = ready_r;
    key_nxt        = key_r;
    cur_nxt        = cur_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = wr_slot;
    mem_wdata      = {in_key, in_write_data};
    mem_re         = 1'b0;
    mem_raddr      = cur_r - ADDR_W'(1);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          res_status_nxt = ST_OK;
          res_data_nxt   = '0;
          state_nxt      = S_RESP;
          case (in_command)
            CMD_INIT: begin
              // before ready the store is fully erased, so the first empty slot is slot 0
              if (!ready_r) begin
                ptr_nxt   = '0;
                ready_nxt = 1'b1;
              end
            end
            CMD_FORMAT: begin
              ptr_nxt   = '0;
              ready_nxt = 1'b1;
            end
            CMD_WRITE: begin
              if (!ready_r) begin
                res_status_nxt = ST_NOT_READY;
              end else begin
                mem_we  = 1'b1;
                ptr_nxt = PTR_W'(wr_slot) + PTR_W'(1);
              end
            end
            CMD_READ: begin
              if (!ready_r) begin
                res_status_nxt = ST_NOT_READY;
              end else if (ptr_r == '0) begin
                res_status_nxt = ST_NOT_FOUND;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = ptr_dec[ADDR_W-1:0];
                cur_nxt   = ptr_dec[ADDR_W-1:0];
                key_nxt   = in_key;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              res_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_SCAN: begin
        // data for cur_r arrives this cycle
        if (hit) begin
          res_status_nxt = ST_OK;
          res_data_nxt   = rd_val;
          state_nxt      = S_RESP;
        end else if (cur_r == '0) begin
          res_status_nxt = ST_NOT_FOUND;
          state_nxt      = S_RESP;
        end else begin
          mem_re  = 1'b1;
          cur_nxt = cur_r - ADDR_W'(1);
        end
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_data_nxt   = res_data_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      ready_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      ready_r     <= ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    cur_r        <= cur_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PTR_W'(SLOTS))
    else $error("write pointer beyond slot count");

  a_scan_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> ready_r && ptr_r != '0)
    else $error("slot scan without ready store");

  a_write_gated: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ready_r && in_accept && in_command == CMD_WRITE)
    else $error("slot program outside an accepted write");

  a_write_advances: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> ptr_r != '0 && state_r == S_RESP)
    else $error("write did not advance pointer");
`endif

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import alkv_pkg::*;

  typedef struct {
    cmd_t        command;
    logic [31:0] key;
    logic [31:0] wdata;
    int unsigned pace;
    bit          drain;
  } store_op_t;

  typedef struct {
    status_t     status;
    logic [31:0] data;
  } store_result_t;

  localparam int PACE_NONE   = 0;
  localparam int PACE_SENDER = 1;
  localparam int PACE_RECV   = 2;
  localparam int PACE_BOTH   = 3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  cmd_t        in_command = CMD_INIT;
  logic [31:0] in_key = '0;
  logic [31:0] in_write_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  status_t     out_status;
  logic [31:0] out_read_data;

  store_op_t     op_q[$];
  store_result_t awaited_results[$];
  int unsigned   pace_mode = PACE_NONE;
  int unsigned   accepted_count = 0;
  int unsigned   total_ops = 0;
  int unsigned   mismatch_count = 0;

  // shadow of the log
  logic [31:0] store_keys [SLOTS];
  logic [31:0] store_vals [SLOTS];
  int          fill_ptr;
  bit          is_ready;

  append_log_key_value_store i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_command    (in_command),
    .in_key        (in_key),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_read_data (out_read_data)
  );

  always #10 clk = ~clk;

  function automatic void erase_store();
    for (int i = 0; i < SLOTS; i++) begin
      store_keys[i] = ERASED;
      store_vals[i] = ERASED;
    end
    fill_ptr = 0;
  endfunction

  function automatic void apply_command(cmd_t cmd, logic [31:0] key, logic [31:0] wdata);
    store_result_t res;
    int            p;
    res.status = ST_OK;
    res.data   = '0;
    case (cmd)
      CMD_INIT: begin
        if (!is_ready) begin
          p = 0;
          while (p < SLOTS && !(store_keys[p] == ERASED && store_vals[p] == ERASED)) p++;
          fill_ptr = p;
          is_ready = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (!is_ready) begin
          res.status = ST_NOT_READY;
        end else begin
          // full log: wipe and restart at the bottom
          if (fill_ptr >= SLOTS) erase_store();
          store_keys[fill_ptr] = key;
          store_vals[fill_ptr] = wdata;
          fill_ptr++;
        end
      end
      CMD_READ: begin
        if (!is_ready) begin
          res.status = ST_NOT_READY;
        end else begin
          res.status = ST_NOT_FOUND;
          p = (fill_ptr > SLOTS) ? SLOTS : fill_ptr;
          while (p > 0 && res.status == ST_NOT_FOUND) begin
            p--;
            if (store_keys[p] != ERASED && store_vals[p] != ERASED && store_keys[p] == key) begin
              res.status = ST_OK;
              res.data   = store_vals[p];
            end
          end
        end
      end
      default: begin
        erase_store();
        is_ready = 1'b1;
      end
    endcase
    awaited_results.push_back(res);
  endfunction

  function automatic bit take_break(int unsigned mode, bit receiver);
    int unsigned pct;
    if (mode == PACE_BOTH) pct = 9;
    else if (mode == (receiver ? PACE_RECV : PACE_SENDER)) pct = 69;
    else pct = 0;
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic push_op(cmd_t cmd, logic [31:0] key, logic [31:0] wdata,
                         int unsigned pace, bit drain);
    store_op_t op;
    op.command = cmd;
    op.key     = key;
    op.wdata   = wdata;
    op.pace    = pace;
    op.drain   = drain;
    op_q.push_back(op);
  endtask

  // driver: predicts each item as it is taken
  always @(posedge clk) begin : drv
    store_op_t op;
    bit        fire;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && !in_stall;
      if (fire) begin
        apply_command(in_command, in_key, in_write_data);
        accepted_count++;
      end
      if (!in_valid || fire) begin
        if (op_q.size() != 0 && !(op_q[0].drain && awaited_results.size() != 0) &&
            !take_break(op_q[0].pace, 1'b0)) begin
          op = op_q.pop_front();
          in_valid      <= 1'b1;
          in_command    <= op.command;
          in_key        <= op.key;
          in_write_data <= op.wdata;
          pace_mode     <= op.pace;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : mon
    store_result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("unexpected item status %0d data %h",
                                    out_status, out_read_data));
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
          if (out_read_data !== want.data)
            report_mismatch($sformatf("read_data %h, want %h", out_read_data, want.data));
        end
      end
      out_stall <= take_break(pace_mode, 1'b1);
    end
  end

  initial begin : stim
    logic [31:0] key_pool [8];
    logic [31:0] k;
    logic [31:0] d;
    int unsigned r;
    int unsigned pace;
    erase_store();
    is_ready = 1'b0;

    // before init, then the erased-word corner cases
    push_op(CMD_READ,   32'h0,         32'h0,         PACE_NONE, 1'b0);
    push_op(CMD_WRITE,  32'h1,         32'h2,         PACE_NONE, 1'b0);
    push_op(CMD_INIT,   32'h0,         32'h0,         PACE_NONE, 1'b0);
    push_op(CMD_INIT,   32'hFFFF_FFFF, 32'hFFFF_FFFF, PACE_NONE, 1'b0);
    push_op(CMD_WRITE,  32'h0,         32'h0,         PACE_NONE, 1'b0);
    push_op(CMD_WRITE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, PACE_NONE, 1'b0);
    push_op(CMD_WRITE,  32'hFFFF_FFFF, 32'h5,         PACE_NONE, 1'b0);
    push_op(CMD_WRITE,  32'h7,         32'hFFFF_FFFF, PACE_NONE, 1'b0);
    push_op(CMD_READ,   32'hFFFF_FFFF, 32'h0,         PACE_NONE, 1'b0);
    push_op(CMD_READ,   32'h7,         32'h0,         PACE_NONE, 1'b0);
    push_op(CMD_READ,   32'h0,         32'h0,         PACE_NONE, 1'b0);
    push_op(CMD_WRITE,  32'h0,         32'h1234_5678, PACE_NONE, 1'b0);
    push_op(CMD_READ,   32'h0,         32'hFFFF_FFFF, PACE_NONE, 1'b0);
    push_op(CMD_WRITE,  32'hFFFF_FFFE, 32'hAAAA_AAAA, PACE_NONE, 1'b0);
    push_op(CMD_WRITE,  32'h1,         32'h5555_5555, PACE_NONE, 1'b0);
    push_op(CMD_READ,   32'hFFFF_FFFE, 32'h0,         PACE_NONE, 1'b0);
    push_op(CMD_READ,   32'h1,         32'h0,         PACE_NONE, 1'b0);
    push_op(CMD_READ,   32'hDEAD_BEEF, 32'h0,         PACE_NONE, 1'b0);
    push_op(CMD_FORMAT, 32'h0,         32'h0,         PACE_NONE, 1'b0);
    push_op(CMD_READ,   32'h0,         32'h0,         PACE_NONE, 1'b0);
    push_op(CMD_WRITE,  32'h8000_0001, 32'hFFFF_FFFE, PACE_NONE, 1'b0);
    push_op(CMD_READ,   32'h8000_0001, 32'h0,         PACE_NONE, 1'b0);
    push_op(CMD_FORMAT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PACE_NONE, 1'b0);
    push_op(CMD_INIT,   32'h0,         32'h0,         PACE_NONE, 1'b0);

    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) key_pool[i] = $urandom;

    // mostly writes and reads on a few keys so reads hit; formats keep the log short
    for (int i = 0; i < 266; i++) begin
      pace = (i * 4) / 266;
      r = $urandom_range(0, 99);
      k = key_pool[$urandom_range(0, 7)];
      d = ($urandom_range(0, 19) == 0) ? ERASED : $urandom;
      if (r < 2)       push_op(CMD_FORMAT, $urandom, $urandom, pace, i % 50 == 0);
      else if (r < 4)  push_op(CMD_INIT, $urandom, $urandom, pace, i % 50 == 0);
      else if (r < 45) push_op(CMD_WRITE, k, d, pace, i % 50 == 0);
      else if (r < 90) push_op(CMD_READ, k, $urandom, pace, i % 50 == 0);
      else if (r < 95) push_op(CMD_WRITE, $urandom, d, pace, i % 50 == 0);
      else             push_op(CMD_READ, $urandom, $urandom, pace, i % 50 == 0);
    end
    total_ops = op_q.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count != total_ops || awaited_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
